// ===== sv/qec_pkg.sv =====
// ----------------------------------------------------------------------------
// qec_pkg: shared types and constants
// Request, result and job types for the quadrature encoder speed counter.
// ----------------------------------------------------------------------------
package qec_pkg;

  localparam int NUM_ENCODERS  = 4;
  localparam int NUM_WHEELS    = 4;
  localparam int FRACTION_BITS = 8;

  localparam int CNT_W   = 32;
  localparam int SCALE_W = 16;
  localparam int WHEEL_W = 2;
  localparam int SRC_W   = 2;
  localparam int PROD_W  = CNT_W + SCALE_W;
  localparam int NUM_W   = PROD_W + FRACTION_BITS;
  localparam int HI_W    = NUM_W - CNT_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int MAP_W      = NUM_WHEELS * SRC_W;

  localparam logic [CFG_IDX_W-1:0] REG_SCALE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INVERT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAP    = 2'd2;

  localparam logic [SCALE_W-1:0]    SCALE_RESET  = 16'd100;
  localparam logic [NUM_WHEELS-1:0] INVERT_RESET = 4'd5;
  localparam logic [MAP_W-1:0]      MAP_RESET    = 8'd180;

  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [CNT_W-1:0] SPEED_MAX = 32'h7FFF_FFFF;
  localparam logic [CNT_W-1:0] SPEED_MIN = 32'h8000_0000;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;

  typedef struct packed {
    logic              op;
    logic [1:0]        channel;
    logic              edge_line;
    logic              other_level;
    logic [CNT_W-1:0]  tick_time;
  } qec_req_t;

  typedef struct packed {
    logic [WHEEL_W-1:0]      wheel;
    logic signed [CNT_W-1:0] speed;
    logic                    zero_interval;
    logic                    last_wheel;
  } qec_res_t;

  typedef struct packed {
    logic [WHEEL_W-1:0] wheel;
    logic [CNT_W-1:0]   dcount;
    logic [CNT_W-1:0]   dtick;
    logic               zero;
    logic               last;
  } qec_job_t;

endpackage

// ===== sv/quad_encoder_counter_speed.sv =====
// An edge request yields no result. A sample request yields four results;
// each wheel passes in turn through the single shared divider (multiply,
// range check, 32 restoring steps, output), the steps being skipped on a
// zero interval or saturation.
// Reset is synchronous: counters, previous counts and tick clear to zero and
// the registers take their default values.
// ----------------------------------------------------------------------------
// quad_encoder_counter_speed: 2x quadrature counter with speed sampling
// Four wrapping edge counters and a per-wheel Q23.8 speed computation.
// ----------------------------------------------------------------------------
module quad_encoder_counter_speed (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  qec_pkg::qec_req_t             req,
  output logic                          full,
  output logic                          empty,
  input  logic                          pop,
  output qec_pkg::qec_res_t             res,
  input  logic                          wr_en,
  input  logic [qec_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [qec_pkg::CFG_DATA_W-1:0] wr_data
);
  import qec_pkg::*;

  logic [SCALE_W-1:0]    scale_factor;
  logic [NUM_WHEELS-1:0] invert_mask;
  logic [MAP_W-1:0]      wheel_source_map;

  logic     q_full;
  logic     q_push;
  logic     q_empty;
  logic     q_pop;
  qec_job_t f_job;
  qec_job_t b_job;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_factor     <= SCALE_RESET;
      invert_mask      <= INVERT_RESET;
      wheel_source_map <= MAP_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SCALE:  scale_factor     <= wr_data[SCALE_W-1:0];
        REG_INVERT: invert_mask      <= wr_data[NUM_WHEELS-1:0];
        REG_MAP:    wheel_source_map <= wr_data[MAP_W-1:0];
        default:    scale_factor     <= scale_factor;
      endcase
    end
  end

  qec_front u_front (
    .clk              (clk),
    .rst              (rst),
    .push             (push),
    .req              (req),
    .busy             (full),
    .invert_mask      (invert_mask),
    .wheel_source_map (wheel_source_map),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (f_job)
  );

  qec_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_job  (f_job),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_job  (b_job),
    .q_empty (q_empty)
  );

  qec_div u_div (
    .clk          (clk),
    .rst          (rst),
    .scale_factor (scale_factor),
    .q_empty      (q_empty),
    .q_job        (b_job),
    .q_pop        (q_pop),
    .empty        (empty),
    .pop          (pop),
    .res          (res)
  );

endmodule

// ===== sv/qec_front.sv =====
// ----------------------------------------------------------------------------
// qec_front: edge counting and sample classification
// Applies edge events to the encoder counters and turns a sample request
// into one speed job per wheel, one job per cycle unless the queue is full.
// ----------------------------------------------------------------------------
module qec_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  qec_pkg::qec_req_t              req,
  output logic                           busy,
  input  logic [qec_pkg::NUM_WHEELS-1:0] invert_mask,
  input  logic [qec_pkg::MAP_W-1:0]      wheel_source_map,
  input  logic                           q_full,
  output logic                           q_push,
  output qec_pkg::qec_job_t              q_job
);
  import qec_pkg::*;

  logic [CNT_W-1:0]   counts [NUM_ENCODERS];
  logic [CNT_W-1:0]   prev_w [NUM_WHEELS];
  logic [CNT_W-1:0]   prev_tick;
  logic [CNT_W-1:0]   dtick;
  logic [WHEEL_W-1:0] widx;
  logic [SRC_W-1:0]   src;
  logic [CNT_W-1:0]   raw;
  logic [CNT_W-1:0]   val;
  logic               accept;
  logic               up;

  assign accept = push && !busy;
  assign up     = ~(req.edge_line ^ req.other_level);

  always_comb begin
    src = wheel_source_map[SRC_W*widx +: SRC_W];
    raw = '0;
    if (int'(src) < NUM_ENCODERS) begin
      raw = counts[src];
    end
    val = invert_mask[widx] ? (~raw + CNT_W'(1)) : raw;
  end

  assign q_push       = busy && !q_full;
  assign q_job.wheel  = widx;
  assign q_job.dcount = val - prev_w[widx];
  assign q_job.dtick  = dtick;
  assign q_job.zero   = (dtick == '0);
  assign q_job.last   = (widx == WHEEL_W'(NUM_WHEELS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      widx      <= '0;
      prev_tick <= '0;
      dtick     <= '0;
      for (int i = 0; i < NUM_ENCODERS; i++) begin
        counts[i] <= '0;
      end
      for (int i = 0; i < NUM_WHEELS; i++) begin
        prev_w[i] <= '0;
      end
    end else begin
      if (accept) begin
        if (req.op == OP_EDGE) begin
          if (int'(req.channel) < NUM_ENCODERS) begin
            counts[req.channel] <= up ? counts[req.channel] + CNT_W'(1)
                                      : counts[req.channel] - CNT_W'(1);
          end
        end else begin
          dtick     <= req.tick_time - prev_tick;
          prev_tick <= req.tick_time;
          widx      <= '0;
          busy      <= 1'b1;
        end
      end
      if (q_push) begin
        prev_w[widx] <= val;
        widx         <= widx + WHEEL_W'(1);
        if (q_job.last) begin
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== sv/qec_queue.sv =====
// ----------------------------------------------------------------------------
// qec_queue: job queue
// Small register queue between the front and the divider.
// ----------------------------------------------------------------------------
module qec_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              wr,
  input  qec_pkg::qec_job_t wr_job,
  output logic              q_full,
  input  logic              rd,
  output qec_pkg::qec_job_t rd_job,
  output logic              q_empty
);
  import qec_pkg::*;

  qec_job_t          slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   fill;
  logic              do_wr;
  logic              do_rd;

  assign q_full  = (fill == (QPTR_W+1)'(QDEPTH));
  assign q_empty = (fill == '0);
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && !q_empty;
  assign rd_job  = slots[rptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (do_rd) begin
        rptr <= rptr + QPTR_W'(1);
      end
      unique case ({do_wr, do_rd})
        2'b10:   fill <= fill + (QPTR_W+1)'(1);
        2'b01:   fill <= fill - (QPTR_W+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== sv/qec_div.sv =====
// ----------------------------------------------------------------------------
// qec_div: speed computation
// Scales the count delta, divides by the tick delta one quotient bit per
// cycle, saturates and holds the result in the output register.
// ----------------------------------------------------------------------------
module qec_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [qec_pkg::SCALE_W-1:0] scale_factor,
  input  logic                        q_empty,
  input  qec_pkg::qec_job_t           q_job,
  output logic                        q_pop,
  output logic                        empty,
  input  logic                        pop,
  output qec_pkg::qec_res_t           res
);
  import qec_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_CHK  = 3'd2;
  localparam logic [2:0] ST_DIV  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]         state;
  logic [WHEEL_W-1:0] wheel;
  logic               zero;
  logic               last;
  logic               neg;
  logic               sat;
  logic [CNT_W-1:0]   mag;
  logic [CNT_W-1:0]   dtick;
  logic [PROD_W-1:0]  prod;
  logic [CNT_W-1:0]   rem;
  logic [CNT_W-1:0]   lo;
  logic [4:0]         cnt;
  logic               out_valid;

  logic [NUM_W-1:0]   num;
  logic [CNT_W:0]     trial;
  logic [CNT_W:0]     diff;
  logic               ge;
  logic [CNT_W-1:0]   speed;
  logic               out_free;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign empty    = !out_valid;
  assign out_free = !out_valid || pop;

  always_comb begin
    num   = NUM_W'(prod) << FRACTION_BITS;
    trial = {rem, lo[CNT_W-1]};
    diff  = trial - {1'b0, dtick};
    ge    = (trial >= {1'b0, dtick});
    if (zero) begin
      speed = '0;
    end else if (sat) begin
      speed = neg ? SPEED_MIN : SPEED_MAX;
    end else if (neg) begin
      speed = lo[CNT_W-1] ? SPEED_MIN : (~lo + CNT_W'(1));
    end else begin
      speed = lo[CNT_W-1] ? SPEED_MAX : lo;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      wheel <= q_job.wheel;
      zero  <= q_job.zero;
      last  <= q_job.last;
      neg   <= q_job.dcount[CNT_W-1];
      mag   <= q_job.dcount[CNT_W-1] ? (~q_job.dcount + CNT_W'(1)) : q_job.dcount;
      dtick <= q_job.dtick;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(mag) * PROD_W'(scale_factor);
    end
    if (state == ST_CHK) begin
      sat <= ({1'b0, CNT_W'(num[NUM_W-1:CNT_W])} >= {1'b0, dtick});
      rem <= CNT_W'(num[NUM_W-1:CNT_W]);
      lo  <= num[CNT_W-1:0];
      cnt <= '0;
    end
    if (state == ST_DIV) begin
      rem <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      lo  <= {lo[CNT_W-2:0], ge};
      cnt <= cnt + 5'd1;
    end
    if (state == ST_OUT && out_free) begin
      res.wheel         <= wheel;
      res.speed         <= speed;
      res.zero_interval <= zero;
      res.last_wheel    <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (!q_empty) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_CHK;
        end
        ST_CHK: begin
          if (zero || ({1'b0, CNT_W'(num[NUM_W-1:CNT_W])} >= {1'b0, dtick})) begin
            state <= ST_OUT;
          end else begin
            state <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (cnt == 5'd31) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // sat is only meaningful after ST_CHK; clear it for the zero-interval path
  // by gating it with zero in the speed select above.

endmodule

// ===== sv/qec_checker.sv =====
// ----------------------------------------------------------------------------
// qec_checker: port-level checks
// Result ordering and field consistency seen at the top-level ports.
// ----------------------------------------------------------------------------
module qec_checker (
  input logic              clk,
  input logic              rst,
  input logic              empty,
  input logic              pop,
  input qec_pkg::qec_res_t res
);
  import qec_pkg::*;

  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result queue not empty after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(res)))
    else $error("waiting result changed");

  a_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.last_wheel) |-> (res.wheel == WHEEL_W'(NUM_WHEELS - 1)))
    else $error("last flag on wrong wheel");

  a_zero: assert property (@(posedge clk) disable iff (rst)
    (!empty && res.zero_interval) |-> (res.speed == '0))
    else $error("zero interval with nonzero speed");

  a_order: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !res.last_wheel) |=>
      (empty || (res.wheel == $past(res.wheel) + WHEEL_W'(1))))
    else $error("wheel results out of order");

endmodule

bind quad_encoder_counter_speed qec_checker u_qec_checker (
  .clk   (clk),
  .rst   (rst),
  .empty (empty),
  .pop   (pop),
  .res   (res)
);

// ===== sim/qec_speed_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qec_speed_checker: prediction and comparison for the encoder speed counter
// Watches the request, result and register ports, keeps its own copy of the
// counters and registers, and matches every result against the oldest due.
// ----------------------------------------------------------------------------
module qec_speed_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  logic                           full,
  input  qec_pkg::qec_req_t              req,
  input  logic                           empty,
  input  logic                           pop,
  input  qec_pkg::qec_res_t              res,
  input  logic                           wr_en,
  input  logic [qec_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [qec_pkg::CFG_DATA_W-1:0] wr_data,
  output int                             fail_count,
  output int                             pending,
  output int                             checked,
  output int                             sat_seen,
  output int                             zero_seen
);
  import qec_pkg::*;

  logic [SCALE_W-1:0]    scale_q;
  logic [NUM_WHEELS-1:0] invert_q;
  logic [MAP_W-1:0]      map_q;
  logic [CNT_W-1:0]      enc_count [NUM_ENCODERS];
  logic [CNT_W-1:0]      last_wheel_count [NUM_WHEELS];
  logic [CNT_W-1:0]      last_tick;
  qec_res_t              wheel_speeds_due [$];
  int                    err_total = 0;
  int                    n_checked = 0;
  int                    n_sat = 0;
  int                    n_zero = 0;

  // signed Q23.8 speed from a wrapped count delta, truncated and saturated
  function automatic logic [CNT_W-1:0] wheel_speed(input logic [CNT_W-1:0] dcount,
                                                   input logic [CNT_W-1:0] dtick,
                                                   input logic [SCALE_W-1:0] scale,
                                                   output bit sat);
    logic [63:0] mag;
    logic [63:0] quot;
    mag  = {32'd0, dcount[CNT_W-1] ? (~dcount + 32'd1) : dcount};
    quot = ((mag * {48'd0, scale}) << FRACTION_BITS) / {32'd0, dtick};
    sat  = 1'b0;
    if (dcount[CNT_W-1]) begin
      if (quot >= 64'h8000_0000) begin
        sat = 1'b1;
        return SPEED_MIN;
      end
      return ~quot[CNT_W-1:0] + 32'd1;
    end
    if (quot > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      return SPEED_MAX;
    end
    return quot[CNT_W-1:0];
  endfunction

  task automatic apply_request(input qec_req_t r);
    logic [CNT_W-1:0] dtick;
    logic [CNT_W-1:0] val;
    logic [SRC_W-1:0] src;
    qec_res_t         e;
    bit               up;
    bit               sat;
    if (r.op == OP_EDGE) begin
      if (int'(r.channel) < NUM_ENCODERS) begin
        up = (r.edge_line == 1'b0) ? (r.other_level == 1'b0) : (r.other_level == 1'b1);
        enc_count[r.channel] = up ? enc_count[r.channel] + 32'd1
                                  : enc_count[r.channel] - 32'd1;
      end
    end else begin
      dtick = r.tick_time - last_tick;
      for (int w = 0; w < NUM_WHEELS; w++) begin
        src = map_q[SRC_W*w +: SRC_W];
        val = (int'(src) < NUM_ENCODERS) ? enc_count[src] : '0;
        if (invert_q[w]) val = ~val + 32'd1;
        e.wheel         = WHEEL_W'(w);
        e.zero_interval = (dtick == '0);
        e.last_wheel    = (w == NUM_WHEELS - 1);
        e.speed         = '0;
        if (dtick != '0) begin
          e.speed = wheel_speed(val - last_wheel_count[w], dtick, scale_q, sat);
          if (sat) n_sat++;
        end else begin
          n_zero++;
        end
        last_wheel_count[w] = val;
        wheel_speeds_due.push_back(e);
      end
      last_tick = r.tick_time;
    end
  endtask

  task automatic flag_error(input string msg);
    err_total++;
    if (err_total <= 10) $display("%0t ERROR: %s", $realtime, msg);
  endtask

  task automatic check_result(input qec_res_t got);
    qec_res_t e;
    if (wheel_speeds_due.size() == 0) begin
      flag_error($sformatf("unexpected result wheel %0d speed %0d zero %0b last %0b",
                           got.wheel, got.speed, got.zero_interval, got.last_wheel));
      return;
    end
    e = wheel_speeds_due.pop_front();
    n_checked++;
    if (got.wheel != e.wheel || got.speed != e.speed ||
        got.zero_interval != e.zero_interval || got.last_wheel != e.last_wheel)
      flag_error($sformatf({"result mismatch: exp wheel %0d speed %0d zero %0b last %0b,",
                            " got wheel %0d speed %0d zero %0b last %0b"},
                           e.wheel, e.speed, e.zero_interval, e.last_wheel,
                           got.wheel, got.speed, got.zero_interval, got.last_wheel));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      scale_q  = SCALE_RESET;
      invert_q = INVERT_RESET;
      map_q    = MAP_RESET;
      for (int i = 0; i < NUM_ENCODERS; i++) enc_count[i] = '0;
      for (int i = 0; i < NUM_WHEELS; i++) last_wheel_count[i] = '0;
      last_tick = '0;
      wheel_speeds_due.delete();
    end else begin
      if (pop && !empty) check_result(res);
      if (wr_en) begin
        case (wr_index)
          REG_SCALE:  scale_q  = wr_data[SCALE_W-1:0];
          REG_INVERT: invert_q = wr_data[NUM_WHEELS-1:0];
          REG_MAP:    map_q    = wr_data[MAP_W-1:0];
          default: ;
        endcase
      end
      if (push && !full) apply_request(req);
    end
    fail_count <= err_total;
    pending    <= wheel_speeds_due.size();
    checked    <= n_checked;
    sat_seen   <= n_sat;
    zero_seen  <= n_zero;
  end

endmodule

// ===== sim/tb_quad_encoder_counter_speed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quad_encoder_counter_speed: testbench for the encoder speed counter
// Drives edge and sample requests with random gaps, drains results with random
// stalls and one long hold, and steps the registers through several settings.
// ----------------------------------------------------------------------------
module tb_quad_encoder_counter_speed;
  import qec_pkg::*;

  localparam int HOLD_CYCLES = 3000;
  localparam int CYCLE_LIMIT = 500000;
  localparam int DRAIN_WAIT  = 200;
  localparam int IDLE_WAIT   = 40;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  push = 1'b0;
  qec_req_t              req = '0;
  logic                  full;
  logic                  empty;
  logic                  pop = 1'b0;
  qec_res_t              res;
  logic                  wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  wr_index = '0;
  logic [CFG_DATA_W-1:0] wr_data = '0;

  int fail_count;
  int pending;
  int checked;
  int sat_seen;
  int zero_seen;

  bit               hold_req = 1'b0;
  int               cycle_cnt = 0;
  int               n_edges = 0;
  int               n_samples = 0;
  int               n_writes = 0;
  logic [CNT_W-1:0] sample_tick = '0;

  quad_encoder_counter_speed uut (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .req      (req),
    .full     (full),
    .empty    (empty),
    .pop      (pop),
    .res      (res),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  qec_speed_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .full       (full),
    .req        (req),
    .empty      (empty),
    .pop        (pop),
    .res        (res),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .sat_seen   (sat_seen),
    .zero_seen  (zero_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d results still due", cycle_cnt, pending);
    $display("== FAIL ==");
    $finish;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [CNT_W-1:0] tick_step();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return $urandom();
    if (r == 2) return $urandom_range(1, 4);
    return $urandom_range(5, 3000);
  endfunction

  function automatic qec_req_t edge_req(input logic [1:0] ch, input logic line,
                                        input logic other);
    qec_req_t r;
    r.op          = OP_EDGE;
    r.channel     = ch;
    r.edge_line   = line;
    r.other_level = other;
    r.tick_time   = $urandom();
    return r;
  endfunction

  // count one step up or down with a random choice of line
  function automatic qec_req_t step_req(input logic [1:0] ch, input logic up);
    logic line;
    line = 1'($urandom_range(0, 1));
    return edge_req(ch, line, line ? up : !up);
  endfunction

  function automatic qec_req_t sample_req(input logic [CNT_W-1:0] tick);
    qec_req_t r;
    r.op          = OP_SAMPLE;
    r.channel     = 2'($urandom_range(0, 3));
    r.edge_line   = 1'($urandom_range(0, 1));
    r.other_level = 1'($urandom_range(0, 1));
    r.tick_time   = tick;
    return r;
  endfunction

  task automatic send_item(input qec_req_t r, input bit no_gap = 1'b0);
    int g;
    push <= 1'b1;
    req  <= r;
    @(posedge clk);
    while (full) @(posedge clk);
    if (r.op == OP_SAMPLE) begin
      n_samples++;
      sample_tick = r.tick_time;
    end else begin
      n_edges++;
    end
    g = no_gap ? 0 : idle_gap();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (IDLE_WAIT) @(posedge clk);
  endtask

  task automatic reg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    wr_en    <= 1'b1;
    wr_index <= idx;
    wr_data  <= val;
    @(posedge clk);
    wr_en <= 1'b0;
    @(posedge clk);
    n_writes++;
  endtask

  task automatic random_block(input int n_items, input bit with_burst);
    int         sent;
    int         r;
    int         len;
    logic [1:0] ch;
    logic       up;
    sent = 0;
    if (with_burst) begin
      // long one-way run on encoder 0 then a one-tick sample: drives saturation
      send_item(sample_req(sample_tick + tick_step()));
      up  = 1'($urandom_range(0, 1));
      len = $urandom_range(135, 150);
      for (int i = 0; i < len; i++) send_item(step_req(2'd0, up), 1'b1);
      send_item(sample_req(sample_tick + 32'd1));
      sent = len + 2;
    end
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        ch  = 2'($urandom_range(0, 3));
        up  = 1'($urandom_range(0, 1));
        len = $urandom_range(1, 8);
        for (int i = 0; i < len; i++) send_item(step_req(ch, up));
        sent += len;
      end else if (r < 55) begin
        send_item(edge_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                           1'($urandom_range(0, 1))));
        sent++;
      end else begin
        send_item(sample_req(sample_tick + tick_step()));
        sent++;
      end
    end
  endtask

  task automatic run_phase(input logic [15:0] scale, input logic [3:0] inv,
                           input logic [7:0] map, input int n_items,
                           input bit with_hold, input bit with_burst);
    wait_idle();
    reg_write(REG_SCALE, scale);
    reg_write(REG_INVERT, CFG_DATA_W'(inv));
    reg_write(REG_MAP, CFG_DATA_W'(map));
    if (with_hold) hold_req = 1'b1;
    random_block(n_items, with_burst);
  endtask

  // result side: random drain with stalls, plus one long hold on request
  initial begin
    int n;
    bit held;
    held = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_req && !held) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      pop <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk);
      n = idle_gap();
      if (n > 0) begin
        pop <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: zero interval out of reset, all edge kinds, tick wrap
    send_item(sample_req(32'd0));
    for (int ch = 0; ch < 4; ch++) begin
      for (int k = 0; k < 4; k++) send_item(edge_req(ch[1:0], k[1], k[0]));
    end
    send_item(edge_req(2'd0, 1'b0, 1'b0));
    send_item(edge_req(2'd0, 1'b0, 1'b0));
    send_item(edge_req(2'd2, 1'b1, 1'b0));
    send_item(sample_req(32'd1));
    send_item(sample_req(32'hFFFF_FFFF));
    send_item(sample_req(32'd3));
    send_item(sample_req(32'd3));

    run_phase(16'hFFFF, 4'h0, 8'hE4, 40, 1'b0, 1'b0);
    run_phase(16'd1, 4'hF, 8'h00, 40, 1'b1, 1'b0);
    wait_idle();
    reg_write(2'd3, 16'hFFFF);
    run_phase(16'd0, 4'hA, 8'hFF, 30, 1'b0, 1'b0);
    run_phase(16'hFFFF, 4'hA, 8'h00, 160, 1'b0, 1'b1);
    run_phase(16'($urandom_range(1, 65535)), 4'($urandom_range(0, 15)),
              8'($urandom_range(0, 255)), 40, 1'b0, 1'b0);
    run_phase(16'd100, 4'h5, 8'hB4, 25, 1'b0, 1'b0);

    push <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d edge and %0d sample requests, %0d register writes, %0d results",
             n_edges, n_samples, n_writes, checked);
    $display("results with saturated speed: %0d, with zero tick interval: %0d",
             sat_seen, zero_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d failures", fail_count);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
